// File: rtl/odwd_pkg.sv
// ----------------------------------------------------------------------------
// odwd_pkg - orientation detector shared types and constants
// Class codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package odwd_pkg;

  localparam int ACCEL_W     = 16;
  localparam int TILT_W      = 15;
  localparam int COUNT_CFG_W = 8;
  localparam int CLS_W       = 3;
  localparam int NUM_CLASSES = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE,
    CLS_UPRIGHT,
    CLS_UPSIDE_DOWN,
    CLS_ROT_CW,
    CLS_ROT_CCW,
    CLS_FACE_UP,
    CLS_FACE_DOWN
  } class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_LOW,
    CFG_TILT_HIGH,
    CFG_COUNT_THR,
    CFG_COUNT_HYS
  } cfg_idx_t;

  typedef struct packed {
    logic [TILT_W-1:0]      tilt_low;
    logic [TILT_W-1:0]      tilt_high;
    logic [COUNT_CFG_W-1:0] count_thr;
    logic [COUNT_CFG_W-1:0] count_hys;
  } cfg_t;

endpackage

// File: rtl/odwd_in_if.sv
// ----------------------------------------------------------------------------
// odwd_in_if - accelerometer sample channel
// Valid/ready channel carrying one three-axis sample per request.
// ----------------------------------------------------------------------------
interface odwd_in_if;
  import odwd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// File: rtl/odwd_out_if.sv
// ----------------------------------------------------------------------------
// odwd_out_if - orientation result channel
// Valid/ready channel carrying one orientation code per request.
// ----------------------------------------------------------------------------
interface odwd_out_if;
  import odwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] new_orientation;

  modport source (output valid, output new_orientation, input ready);
  modport sink   (input valid, input new_orientation, output ready);
endinterface

// File: rtl/odwd_classify.sv
// ----------------------------------------------------------------------------
// odwd_classify - six-way orientation classifier
// Compares axis magnitudes and signs against the tilt thresholds.
// ----------------------------------------------------------------------------
module odwd_classify (
  input  logic signed [odwd_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [odwd_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [odwd_pkg::ACCEL_W-1:0] accel_z,
  input  logic [odwd_pkg::TILT_W-1:0]         tilt_low,
  input  logic [odwd_pkg::TILT_W-1:0]         tilt_high,
  output odwd_pkg::class_t                    cand
);
  import odwd_pkg::*;

  logic [ACCEL_W-1:0]        mag_x, mag_y, mag_z;
  logic [ACCEL_W-1:0]        lo_ext;
  logic signed [ACCEL_W:0]   hi_pos, hi_neg;
  logic signed [ACCEL_W:0]   sx, sy, sz;

  // magnitude of -32768 is 32768, still fits unsigned 16 bits
  assign mag_x  = accel_x[ACCEL_W-1] ? (~accel_x + 1'b1) : accel_x;
  assign mag_y  = accel_y[ACCEL_W-1] ? (~accel_y + 1'b1) : accel_y;
  assign mag_z  = accel_z[ACCEL_W-1] ? (~accel_z + 1'b1) : accel_z;
  assign lo_ext = ACCEL_W'(tilt_low);
  assign hi_pos = $signed({2'b00, tilt_high});
  assign hi_neg = -hi_pos;
  assign sx     = {accel_x[ACCEL_W-1], accel_x};
  assign sy     = {accel_y[ACCEL_W-1], accel_y};
  assign sz     = {accel_z[ACCEL_W-1], accel_z};

  always_comb begin
    cand = CLS_NONE;
    if (mag_z < lo_ext) begin
      if (mag_x < lo_ext) begin
        if (sy > hi_pos)      cand = CLS_UPRIGHT;
        else if (sy < hi_neg) cand = CLS_UPSIDE_DOWN;
      end else if (mag_y < lo_ext) begin
        if (sx > hi_pos)      cand = CLS_ROT_CW;
        else if (sx < hi_neg) cand = CLS_ROT_CCW;
      end
    end else begin
      if (sz > hi_pos)        cand = CLS_FACE_UP;
      else if (sz < hi_neg)   cand = CLS_FACE_DOWN;
    end
  end

endmodule

// File: rtl/odwd_debounce.sv
// ----------------------------------------------------------------------------
// odwd_debounce - per-class debounce counters and change detection
// Updates all class counters in parallel, picks the detected class and
// reports it when it differs from the last reported orientation.
// ----------------------------------------------------------------------------
module odwd_debounce #(
  parameter int COUNTER_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  odwd_pkg::class_t                 cand,
  input  logic [odwd_pkg::COUNT_CFG_W-1:0] count_thr,
  input  logic [odwd_pkg::COUNT_CFG_W-1:0] count_hys,
  output odwd_pkg::class_t                 result
);
  import odwd_pkg::*;

  localparam int SUM_W = COUNT_CFG_W + 1;
  localparam int CMP_W = (COUNTER_BITS > SUM_W) ? COUNTER_BITS : SUM_W;

  logic [COUNTER_BITS-1:0] cnt_r   [NUM_CLASSES];
  logic [COUNTER_BITS-1:0] cnt_nxt [NUM_CLASSES];
  class_t                  last_r, last_nxt;
  class_t                  detected;
  logic [SUM_W-1:0]        sum;
  logic [CMP_W-1:0]        sum_ext, ctr_max, limit, thr_ext;

  assign sum     = {1'b0, count_thr} + {1'b0, count_hys};
  assign sum_ext = CMP_W'(sum);
  assign ctr_max = CMP_W'({COUNTER_BITS{1'b1}});
  assign limit   = (sum_ext > ctr_max) ? ctr_max : sum_ext;
  assign thr_ext = CMP_W'(count_thr);

  always_comb begin
    detected = CLS_NONE;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (CLS_W'(i) == cand) begin
        if (CMP_W'(cnt_r[i]) < limit) cnt_nxt[i] = cnt_r[i] + 1'b1;
      end else if (cnt_r[i] != '0) begin
        cnt_nxt[i] = cnt_r[i] - 1'b1;
      end
      if (CMP_W'(cnt_nxt[i]) > thr_ext) detected = class_t'(CLS_W'(i));
    end
  end

  always_comb begin
    result   = CLS_NONE;
    last_nxt = last_r;
    if (detected != CLS_NONE && detected != last_r) begin
      result   = detected;
      last_nxt = detected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= CLS_NONE;
      for (int i = 0; i < NUM_CLASSES; i++) cnt_r[i] <= '0;
    end else if (step) begin
      last_r <= last_nxt;
      for (int i = 0; i < NUM_CLASSES; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

`ifndef ASSERT_OFF
  a_last_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    last_r != CLS_NONE |=> last_r != CLS_NONE)
    else $error("last reported orientation fell back to unknown");

  a_report_remembered: assert property (@(posedge clk) disable iff (!rst_n)
    step && result != CLS_NONE |=> last_r == $past(result))
    else $error("reported orientation not remembered");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    step && result != CLS_NONE |-> result != last_r)
    else $error("orientation reported twice in a row");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(last_r) && $stable(cnt_r[0]) && $stable(cnt_r[6]))
    else $error("debounce state changed without a sample");
`endif

endmodule

// File: rtl/orientation_detector_with_debounce.sv
// ----------------------------------------------------------------------------
// orientation_detector_with_debounce - six-way orientation detector
// Classifies accelerometer samples and debounces the orientation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one x/y/z sample in milli-g per request (valid/ready).
//   out_ch : one result per sample; new_orientation is 1..6 when a newly
//            detected orientation differs from the last one reported,
//            else 0.
//   cfg_*  : write enable, register index and data; write only while idle.
// Timing:
//   A sample is taken into the input register; its result is registered in
//   the output register once the output is free. One sample per cycle while
//   out_ch.ready is high; the seven counters update in one pass.
// Reset (rst_n low at a clock edge): counters and last orientation clear,
//   thresholds go to 0/0, count threshold 10, hysteresis 5.
// Stall: while out_ch.ready is low the finished result holds and one more
//   sample is taken if the input register is empty; then in_ch.ready drops.
// ----------------------------------------------------------------------------
module orientation_detector_with_debounce #(
  parameter int COUNTER_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  odwd_in_if.sink                         in_ch,
  odwd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  odwd_pkg::cfg_idx_t              cfg_idx,
  input  logic [odwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import odwd_pkg::*;

  cfg_t                      cfg_r;
  logic                      in_valid_r;
  logic signed [ACCEL_W-1:0] ax_r, ay_r, az_r;
  logic                      out_valid_r;
  class_t                    res_r;
  logic                      advance;
  logic                      step;
  class_t                    cand;
  class_t                    result;

  assign advance         = !out_valid_r || out_ch.ready;
  assign in_ch.ready     = !in_valid_r || advance;
  assign step            = in_valid_r && advance;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_orientation = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_low  <= '0;
      cfg_r.tilt_high <= '0;
      cfg_r.count_thr <= COUNT_CFG_W'(10);
      cfg_r.count_hys <= COUNT_CFG_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TILT_LOW:  cfg_r.tilt_low  <= cfg_wdata[TILT_W-1:0];
        CFG_TILT_HIGH: cfg_r.tilt_high <= cfg_wdata[TILT_W-1:0];
        CFG_COUNT_THR: cfg_r.count_thr <= cfg_wdata[COUNT_CFG_W-1:0];
        CFG_COUNT_HYS: cfg_r.count_hys <= cfg_wdata[COUNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r  <= in_ch.valid;
      if (advance)     out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      ax_r <= in_ch.accel_x;
      ay_r <= in_ch.accel_y;
      az_r <= in_ch.accel_z;
    end
    if (step) res_r <= result;
  end

  odwd_classify u_classify (
    .accel_x   (ax_r),
    .accel_y   (ay_r),
    .accel_z   (az_r),
    .tilt_low  (cfg_r.tilt_low),
    .tilt_high (cfg_r.tilt_high),
    .cand      (cand)
  );

  odwd_debounce #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cand      (cand),
    .count_thr (cfg_r.count_thr),
    .count_hys (cfg_r.count_hys),
    .result    (result)
  );

endmodule
